>>> sv/lud_pkg.sv
// lud_pkg: shared constants, types and arithmetic helpers for the lu block
// no dependencies; imported by the interfaces, the divider and the top level
package lud_pkg;

  localparam int MAX_DIM   = 4;
  localparam int MIN_DIM   = 2;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int CELLS     = MAX_DIM * MAX_DIM;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int POS_W     = 2;
  localparam int SIZE_W    = 3;
  localparam int CNT_W     = 5;
  localparam int ACC_W     = DATA_W + 4;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int PADDR_W   = 3;
  localparam int DSTEP_W   = 4;

  localparam logic signed [DATA_W-1:0] ONE_FX  = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] FX_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] FX_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(64'd1 << (FRAC_BITS - 1));

  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(MAX_DIM);

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_MATRIX_SIZE = '0;

  // determinant step operations
  localparam logic [1:0] DOP_FIRST = 2'd0;
  localparam logic [1:0] DOP_SUB   = 2'd1;
  localparam logic [1:0] DOP_ADD   = 2'd2;

  localparam logic [DSTEP_W-1:0] DET3_BASE = DSTEP_W'(0);
  localparam logic [DSTEP_W-1:0] DET2_BASE = DSTEP_W'(9);

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     sat;
  } fx_res_t;

  typedef struct packed {
    logic             a_tmp;   // operand a from a minor register
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
    logic [1:0]       op;
    logic             store;   // keep the result as a minor
    logic [1:0]       t_idx;
    logic             last;
  } det_step_t;

  function automatic fx_res_t sat_acc(input logic signed [ACC_W-1:0] a);
    fx_res_t r;
    r.sat = !((&a[ACC_W-1:DATA_W-1]) || !(|a[ACC_W-1:DATA_W-1]));
    r.val = r.sat ? (a[ACC_W-1] ? FX_MIN : FX_MAX) : a[DATA_W-1:0];
    return r;
  endfunction

  // round half up, floor shift, saturate
  function automatic fx_res_t mul_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] q;
    fx_res_t r;
    s = p + ROUND_C;
    q = s >>> FRAC_BITS;
    r.sat = !((&q[PROD_W-1:DATA_W-1]) || !(|q[PROD_W-1:DATA_W-1]));
    r.val = r.sat ? (q[PROD_W-1] ? FX_MIN : FX_MAX) : q[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] cell_idx(input logic [DIM_W-1:0] r,
                                                 input logic [DIM_W-1:0] c);
    return IDX_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // cofactor programs: size 3 from DET3_BASE, size 2 from DET2_BASE
  function automatic det_step_t det_step(input logic [DSTEP_W-1:0] s);
    det_step_t d;
    d = '0;
    case (s)
      4'd0:    d = '{1'b0, IDX_W'(4), IDX_W'(8), DOP_FIRST, 1'b0, 2'd0, 1'b0};
      4'd1:    d = '{1'b0, IDX_W'(5), IDX_W'(7), DOP_SUB,   1'b1, 2'd0, 1'b0};
      4'd2:    d = '{1'b0, IDX_W'(3), IDX_W'(8), DOP_FIRST, 1'b0, 2'd0, 1'b0};
      4'd3:    d = '{1'b0, IDX_W'(5), IDX_W'(6), DOP_SUB,   1'b1, 2'd1, 1'b0};
      4'd4:    d = '{1'b0, IDX_W'(3), IDX_W'(7), DOP_FIRST, 1'b0, 2'd0, 1'b0};
      4'd5:    d = '{1'b0, IDX_W'(4), IDX_W'(6), DOP_SUB,   1'b1, 2'd2, 1'b0};
      4'd6:    d = '{1'b1, IDX_W'(0), IDX_W'(0), DOP_FIRST, 1'b0, 2'd0, 1'b0};
      4'd7:    d = '{1'b1, IDX_W'(1), IDX_W'(1), DOP_SUB,   1'b0, 2'd0, 1'b0};
      4'd8:    d = '{1'b1, IDX_W'(2), IDX_W'(2), DOP_ADD,   1'b0, 2'd0, 1'b1};
      4'd9:    d = '{1'b0, IDX_W'(0), IDX_W'(3), DOP_FIRST, 1'b0, 2'd0, 1'b0};
      4'd10:   d = '{1'b0, IDX_W'(1), IDX_W'(2), DOP_SUB,   1'b0, 2'd0, 1'b1};
      default: d = '{1'b0, IDX_W'(0), IDX_W'(0), DOP_FIRST, 1'b0, 2'd0, 1'b1};
    endcase
    return d;
  endfunction

endpackage

>>> sv/lud_if.sv
// lud_if: valid/ready channels for matrix elements and lu results
// depends on lud_pkg
interface lud_in_if import lud_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element_value;

  modport source(output valid, output element_value, input ready);
  modport sink(input valid, input element_value, output ready);
endinterface

interface lud_out_if import lud_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         row_index;
  logic [POS_W-1:0]         col_index;
  logic signed [DATA_W-1:0] lower_value;
  logic signed [DATA_W-1:0] upper_value;
  logic signed [DATA_W-1:0] determinant;
  logic                     zero_pivot;
  logic                     overflow;
  logic                     last_result;

  modport source(output valid, output row_index, output col_index, output lower_value,
                 output upper_value, output determinant, output zero_pivot,
                 output overflow, output last_result, input ready);
  modport sink(input valid, input row_index, input col_index, input lower_value,
               input upper_value, input determinant, input zero_pivot,
               input overflow, input last_result, output ready);
endinterface

>>> sv/lud_div.sv
// lud_div: bit-serial signed fixed-point divider, one quotient bit per cycle
// depends on lud_pkg
module lud_div import lud_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DATA_W-1:0] num,
  input  logic signed [DATA_W-1:0] den,
  output logic                     done,
  output fx_res_t                  quot
);

  localparam int DVD_W  = DATA_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] dsr_r, dsr_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W:0]   trial;
  logic              qbit;
  logic [DATA_W-1:0] num_mag;
  logic              big_neg;

  assign num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
  assign trial   = {rem_r, dvd_r[DVD_W-1]};
  assign qbit    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = {num_mag, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      dsr_nxt  = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
      neg_nxt  = num[DATA_W-1] ^ den[DATA_W-1];
    end else if (busy_r) begin
      rem_nxt = qbit ? DATA_W'(trial - {1'b0, dsr_r}) : trial[DATA_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], qbit};
      if (step_r == STEP_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    neg_r  <= neg_nxt;
  end

  // magnitude above 2^31 cannot be represented even when negated
  assign big_neg = (|dvd_r[DVD_W-1:DATA_W]) ||
                   (dvd_r[DATA_W-1] && (|dvd_r[DATA_W-2:0]));

  always_comb begin
    if (!neg_r) begin
      quot.sat = |dvd_r[DVD_W-1:DATA_W-1];
      quot.val = quot.sat ? FX_MAX : dvd_r[DATA_W-1:0];
    end else begin
      quot.sat = big_neg;
      quot.val = big_neg ? FX_MIN : DATA_W'(-dvd_r[DATA_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

>>> sv/lu_decompose_determinant.sv
// lu_decompose_determinant: doolittle lu factoring and determinant, q16.16
// depends on lud_pkg, lud_in_if / lud_out_if and lud_div
//
//   port      dir  handshake           carries
//   in_ch     in   valid/ready         element_value, row-major
//   out_ch    out  valid/ready         position, l, u, determinant, flags
//   cfg_*     in   apb write/read      matrix_size at byte address 0
//
// loading takes one element per cycle while in_ch.valid is high; after the
// last one the block runs each multiply-accumulate through the fa, fb and facc
// states on the shared multiplier and each l quotient through the bit-serial
// divider, forms the determinant, then gives n*n results
// rst_n is synchronous; no clearing pass is needed
// in_ch.ready is high only while loading; a stalled result holds its payload
module lu_decompose_determinant import lud_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  lud_in_if.sink             in_ch,
  lud_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // sequencer states
  localparam logic [3:0] ST_LOAD    = 4'd0;
  localparam logic [3:0] ST_EL_INIT = 4'd1;
  localparam logic [3:0] ST_FA      = 4'd2;
  localparam logic [3:0] ST_FB      = 4'd3;
  localparam logic [3:0] ST_FACC    = 4'd4;
  localparam logic [3:0] ST_EL_END  = 4'd5;
  localparam logic [3:0] ST_PIV     = 4'd6;
  localparam logic [3:0] ST_DIV     = 4'd7;
  localparam logic [3:0] ST_DA      = 4'd8;
  localparam logic [3:0] ST_DB      = 4'd9;
  localparam logic [3:0] ST_DACC    = 4'd10;
  localparam logic [3:0] ST_OUT     = 4'd11;

  // storage: input in load order, l and u with row stride MAX_DIM
  logic signed [DATA_W-1:0] a_mem [CELLS];
  logic signed [DATA_W-1:0] l_mem [CELLS];
  logic signed [DATA_W-1:0] u_mem [CELLS];
  logic signed [DATA_W-1:0] t_r   [3];     // 2x2 minors for the size-3 cofactor form

  logic [3:0]               state_r, state_nxt;
  logic [SIZE_W-1:0]        size_r, size_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]        n_r, n_nxt;
  logic [DIM_W-1:0]         i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic                     ph_r, ph_nxt;        // 0 = u row, 1 = l column
  logic                     prodm_r, prodm_nxt;  // determinant as product of u diagonal
  logic [DSTEP_W-1:0]       ds_r, ds_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [DATA_W-1:0] opa_r, opa_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [DATA_W-1:0] piv_r, piv_nxt;
  logic signed [DATA_W-1:0] det_r, det_nxt;
  logic                     pz_r, pz_nxt;
  logic                     ov_r, ov_nxt;
  logic [DIM_W-1:0]         or_r, or_nxt, oc_r, oc_nxt;

  logic [SIZE_W-1:0]        dim;
  logic [CNT_W-1:0]         nsq, cnt_inc, flat;
  logic [DIM_W-1:0]         nm1, row, col;
  logic [IDX_W-1:0]         a_rd_idx, l_rd_idx, u_rd_idx;
  logic signed [DATA_W-1:0] a_rd, l_rd, u_rd, b_op;
  det_step_t                step;
  fx_res_t                  m_res, s_res, n_res, q_res;
  logic                     in_fire, out_fire, cfg_wr;
  logic                     a_we, l_we, u_we, t_we;
  logic [IDX_W-1:0]         l_widx, u_widx;
  logic signed [DATA_W-1:0] l_wdata;
  logic                     div_start, div_done;

  // size clamp
  always_comb begin
    if (size_r < SIZE_W'(MIN_DIM))      dim = SIZE_W'(MIN_DIM);
    else if (size_r > SIZE_W'(MAX_DIM)) dim = SIZE_W'(MAX_DIM);
    else                                dim = size_r;
  end

  assign nsq     = CNT_W'(dim) * CNT_W'(dim);
  assign cnt_inc = cnt_r + 1'b1;
  assign nm1     = DIM_W'(n_r - 1'b1);
  assign row     = ph_r ? j_r : i_r;
  assign col     = ph_r ? i_r : j_r;
  assign flat    = CNT_W'(row) * CNT_W'(n_r) + CNT_W'(col);
  assign step    = det_step(ds_r);

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];

  // one read address per store each cycle
  always_comb begin
    case (state_r)
      ST_EL_INIT: a_rd_idx = flat[IDX_W-1:0];
      ST_DA:      a_rd_idx = step.a_idx;
      default:    a_rd_idx = step.b_idx;
    endcase
    l_rd_idx = (state_r == ST_OUT) ? cell_idx(or_r, oc_r) : cell_idx(row, k_r);
    case (state_r)
      ST_FB:   u_rd_idx = cell_idx(k_r, col);
      ST_OUT:  u_rd_idx = cell_idx(or_r, oc_r);
      default: u_rd_idx = cell_idx(i_r, i_r);
    endcase
  end

  assign a_rd = a_mem[a_rd_idx];
  assign l_rd = l_mem[l_rd_idx];
  assign u_rd = u_mem[u_rd_idx];

  assign m_res = mul_round(prod_r);
  assign s_res = sat_acc(acc_r);

  lud_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (s_res.val),
    .den   (piv_r),
    .done  (div_done),
    .quot  (q_res)
  );

  always_comb begin
    state_nxt = state_r;
    size_nxt  = cfg_wr ? cfg_pwdata[SIZE_W-1:0] : size_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    ph_nxt    = ph_r;
    prodm_nxt = prodm_r;
    ds_nxt    = ds_r;
    acc_nxt   = acc_r;
    opa_nxt   = opa_r;
    prod_nxt  = prod_r;
    piv_nxt   = piv_r;
    det_nxt   = det_r;
    pz_nxt    = pz_r;
    ov_nxt    = ov_r;
    or_nxt    = or_r;
    oc_nxt    = oc_r;
    a_we      = 1'b0;
    l_we      = 1'b0;
    u_we      = 1'b0;
    t_we      = 1'b0;
    l_widx    = cell_idx(j_r, i_r);
    u_widx    = cell_idx(i_r, j_r);
    l_wdata   = '0;
    div_start = 1'b0;
    b_op      = prodm_r ? u_rd : a_rd;
    n_res     = m_res;

    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          a_we = 1'b1;
          if (cnt_inc >= nsq) begin
            cnt_nxt   = '0;
            n_nxt     = dim;
            i_nxt     = '0;
            j_nxt     = '0;
            ph_nxt    = 1'b0;
            pz_nxt    = 1'b0;
            ov_nxt    = 1'b0;
            state_nxt = ST_EL_INIT;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      ST_EL_INIT: begin
        acc_nxt   = ACC_W'(a_rd);
        k_nxt     = '0;
        state_nxt = (i_r == '0) ? ST_EL_END : ST_FA;
      end
      ST_FA: begin
        opa_nxt   = l_rd;
        state_nxt = ST_FB;
      end
      ST_FB: begin
        prod_nxt  = PROD_W'(opa_r) * PROD_W'(u_rd);
        state_nxt = ST_FACC;
      end
      ST_FACC: begin
        // the running sum stays wide until it is stored
        acc_nxt = acc_r - ACC_W'(m_res.val);
        ov_nxt  = ov_r | m_res.sat;
        if (k_r == DIM_W'(i_r - 1'b1)) begin
          state_nxt = ST_EL_END;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_FA;
        end
      end
      ST_EL_END: begin
        if (!ph_r) begin
          u_we   = 1'b1;
          ov_nxt = ov_r | s_res.sat;
          if (j_r == nm1) begin
            state_nxt = ST_PIV;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_EL_INIT;
          end
        end else if (piv_r == '0) begin
          // zero pivot: quotient forced to zero, no saturation check
          l_we = 1'b1;
          if (j_r == nm1) begin
            i_nxt  = i_r + 1'b1;
            j_nxt  = i_r + 1'b1;
            ph_nxt = 1'b0;
          end else begin
            j_nxt = j_r + 1'b1;
          end
          state_nxt = ST_EL_INIT;
        end else begin
          ov_nxt    = ov_r | s_res.sat;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_PIV: begin
        piv_nxt = u_rd;
        if (u_rd == '0) pz_nxt = 1'b1;
        if (i_r == nm1) begin
          i_nxt     = '0;
          prodm_nxt = n_r > SIZE_W'(3);
          ds_nxt    = (n_r == SIZE_W'(3)) ? DET3_BASE : DET2_BASE;
          state_nxt = ST_DA;
        end else begin
          ph_nxt    = 1'b1;
          j_nxt     = i_r + 1'b1;
          state_nxt = ST_EL_INIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          l_we    = 1'b1;
          l_wdata = q_res.val;
          ov_nxt  = ov_r | q_res.sat;
          if (j_r == nm1) begin
            i_nxt  = i_r + 1'b1;
            j_nxt  = i_r + 1'b1;
            ph_nxt = 1'b0;
          end else begin
            j_nxt = j_r + 1'b1;
          end
          state_nxt = ST_EL_INIT;
        end
      end
      ST_DA: begin
        if (prodm_r)         opa_nxt = (i_r == '0) ? ONE_FX : acc_r[DATA_W-1:0];
        else if (step.a_tmp) opa_nxt = t_r[step.a_idx[1:0]];
        else                 opa_nxt = a_rd;
        state_nxt = ST_DB;
      end
      ST_DB: begin
        prod_nxt  = PROD_W'(opa_r) * PROD_W'(b_op);
        state_nxt = ST_DACC;
      end
      ST_DACC: begin
        // cofactor form saturates after every add
        if (!prodm_r) begin
          case (step.op)
            DOP_SUB: n_res = sat_acc(acc_r - ACC_W'(m_res.val));
            DOP_ADD: n_res = sat_acc(acc_r + ACC_W'(m_res.val));
            default: n_res = m_res;
          endcase
        end
        acc_nxt = ACC_W'(n_res.val);
        ov_nxt  = ov_r | m_res.sat | n_res.sat;
        t_we    = !prodm_r && step.store;
        if (prodm_r ? (i_r == nm1) : step.last) begin
          det_nxt   = n_res.val;
          or_nxt    = '0;
          oc_nxt    = '0;
          state_nxt = ST_OUT;
        end else begin
          i_nxt     = prodm_r ? i_r + 1'b1 : i_r;
          ds_nxt    = ds_r + 1'b1;
          state_nxt = ST_DA;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          if (oc_r == nm1) begin
            oc_nxt = '0;
            if (or_r == nm1) state_nxt = ST_LOAD;
            else             or_nxt = or_r + 1'b1;
          end else begin
            oc_nxt = oc_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      size_r  <= RESET_SIZE;
      cnt_r   <= '0;
      pz_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      cnt_r   <= cnt_nxt;
      pz_r    <= pz_nxt;
      ov_r    <= ov_nxt;
    end
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    ph_r    <= ph_nxt;
    prodm_r <= prodm_nxt;
    ds_r    <= ds_nxt;
    acc_r   <= acc_nxt;
    opa_r   <= opa_nxt;
    prod_r  <= prod_nxt;
    piv_r   <= piv_nxt;
    det_r   <= det_nxt;
    or_r    <= or_nxt;
    oc_r    <= oc_nxt;
  end

  always_ff @(posedge clk) begin
    if (a_we) a_mem[cnt_r[IDX_W-1:0]] <= in_ch.element_value;
    if (l_we) l_mem[l_widx] <= l_wdata;
    if (u_we) u_mem[u_widx] <= s_res.val;
    if (t_we) t_r[step.t_idx] <= n_res.val;
  end

  // ports
  assign in_ch.ready = (state_r == ST_LOAD);

  assign out_ch.valid       = (state_r == ST_OUT);
  assign out_ch.row_index   = POS_W'(or_r);
  assign out_ch.col_index   = POS_W'(oc_r);
  assign out_ch.lower_value = (or_r > oc_r) ? l_rd : ((or_r == oc_r) ? ONE_FX : '0);
  assign out_ch.upper_value = (or_r > oc_r) ? '0 : u_rd;
  assign out_ch.last_result = (or_r == nm1) && (oc_r == nm1);
  assign out_ch.determinant = out_ch.last_result ? det_r : '0;
  assign out_ch.zero_pivot  = pz_r;
  assign out_ch.overflow    = ov_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MATRIX_SIZE[2]) ? 32'(size_r) : '0;

`ifndef SYNTH
  a_load_excl_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input accepted while results pending");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (piv_r != '0))
    else $error("divider started on a zero pivot");

  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_result) |=> in_ch.ready)
    else $error("no return to loading after the last result");
`endif

endmodule
